FILE: rtl/pipt_pkg.sv
package pipt_pkg;

    // Geometry limits
    localparam int MAX_VERTICES = 8;
    localparam int COORD_WIDTH  = 20;
    localparam int PAIR_REGS    = 4;
    localparam int REG_VERTICES = 2 * PAIR_REGS;
    localparam int LANES        = (MAX_VERTICES < REG_VERTICES) ? MAX_VERTICES : REG_VERTICES;

    // Field and datapath widths
    localparam int VTX_W    = 16;                 // signed Q8.8 vertex offset
    localparam int PAIR_W   = 4 * VTX_W;          // one vertex pair register
    localparam int CNT_W    = 4;                  // vertex count and crossing count
    localparam int CFG_IDX_W = 3;
    localparam int PT_W     = COORD_WIDTH + 1;    // query relative to object
    localparam int DX_W     = PT_W + 1;           // point minus vertex
    localparam int DV_W     = VTX_W + 1;          // vertex minus vertex
    localparam int PROD_W   = DX_W + DV_W;        // exact cross product term

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VERTEX_COUNT = 3'd0,
        REG_PAIR_0       = 3'd1,
        REG_PAIR_1       = 3'd2,
        REG_PAIR_2       = 3'd3,
        REG_PAIR_3       = 3'd4
    } t_cfg_reg;

    // Input word
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] query_x;
        logic signed [COORD_WIDTH-1:0] query_y;
        logic signed [COORD_WIDTH-1:0] object_x;
        logic signed [COORD_WIDTH-1:0] object_y;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic             inside_res;
        logic [CNT_W-1:0] crossing_count;
    } t_out_word;

endpackage

FILE: rtl/pipt_edge.sv
module pipt_edge (
    input  logic                              i_active,
    input  logic signed [pipt_pkg::PT_W-1:0]  i_px,
    input  logic signed [pipt_pkg::PT_W-1:0]  i_py,
    input  logic signed [pipt_pkg::VTX_W-1:0] i_xi,
    input  logic signed [pipt_pkg::VTX_W-1:0] i_yi,
    input  logic signed [pipt_pkg::VTX_W-1:0] i_xj,
    input  logic signed [pipt_pkg::VTX_W-1:0] i_yj,
    output logic                              o_hit
);
    import pipt_pkg::*;

    logic signed [DV_W-1:0]   w_d;
    logic signed [DV_W-1:0]   w_ex;
    logic signed [DX_W-1:0]   w_dx;
    logic signed [DX_W-1:0]   w_ey;
    logic signed [PROD_W-1:0] w_lhs;
    logic signed [PROD_W-1:0] w_rhs;
    logic                     w_straddle;

    // Edge differences and the two cross-multiplied terms
    always_comb begin
        w_d        = DV_W'(i_yj) - DV_W'(i_yi);
        w_ex       = DV_W'(i_xj) - DV_W'(i_xi);
        w_dx       = DX_W'(i_px) - DX_W'(i_xi);
        w_ey       = DX_W'(i_py) - DX_W'(i_yi);
        w_lhs      = PROD_W'(w_dx) * PROD_W'(w_d);
        w_rhs      = PROD_W'(w_ex) * PROD_W'(w_ey);
        w_straddle = (PT_W'(i_yi) > i_py) != (PT_W'(i_yj) > i_py);
    end

    // Flip the compare when the edge runs downward
    assign o_hit = i_active && w_straddle
                   && (w_d[DV_W-1] ? (w_lhs > w_rhs) : (w_lhs < w_rhs));

endmodule

FILE: rtl/point_in_polygon_test_unit.sv
// Even-odd point-in-polygon test with a rightward ray.
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is high.
// Index 0 is the vertex count, indexes 1 to 4 hold vertex pairs as Q8.8
// offsets from the object position. Other indexes are ignored. Write only
// while no word is in flight.
// Input channel: i_in_valid / o_in_ready carry a query point and an object
// position. Output channel: o_out_valid / i_out_ready carry the inside flag
// and the number of crossed edges, one result word per input word, in order.
// An accepted word passes the input register, then the result register.
// Throughput: one word per cycle unless the receiver stalls, set by two register
// stages (input, result) with every edge tested in its own lane between them.
// When the receiver stalls, the result holds and the input register still
// takes one more word; o_in_ready drops only once both stages are full.
// Reset clears the vertex count and vertex registers and empties the pipeline.
module point_in_polygon_test_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pipt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pipt_pkg::PAIR_W-1:0]          i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  pipt_pkg::t_in_word                   i_in_word,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output pipt_pkg::t_out_word                  o_out_word
);
    import pipt_pkg::*;

    logic [CNT_W-1:0]  r_vcnt;
    logic [PAIR_W-1:0] r_pair [PAIR_REGS];

    t_in_word          r_in;
    logic              r_in_vld;
    t_out_word         r_out;
    logic              r_out_vld;

    logic              w_out_free;
    logic              w_in_free;
    logic              n_in_vld;
    logic              n_out_vld;

    logic [CNT_W-1:0]  w_nvert;
    logic              w_enough;
    logic signed [PT_W-1:0]  w_px;
    logic signed [PT_W-1:0]  w_py;
    logic signed [VTX_W-1:0] w_vx [LANES];
    logic signed [VTX_W-1:0] w_vy [LANES];
    logic [LANES-1:0]  w_hit;
    logic [CNT_W-1:0]  w_sum;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt <= '0;
            for (int k = 0; k < PAIR_REGS; k++) begin
                r_pair[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_VERTEX_COUNT: r_vcnt    <= i_cfg_data[CNT_W-1:0];
                REG_PAIR_0:       r_pair[0] <= i_cfg_data;
                REG_PAIR_1:       r_pair[1] <= i_cfg_data;
                REG_PAIR_2:       r_pair[2] <= i_cfg_data;
                REG_PAIR_3:       r_pair[3] <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // Stage flow: a stage takes a new word when it is empty or drains
    always_comb begin
        w_out_free = !r_out_vld || i_out_ready;
        w_in_free  = !r_in_vld || w_out_free;
        n_in_vld   = w_in_free  ? i_in_valid : r_in_vld;
        n_out_vld  = w_out_free ? r_in_vld   : r_out_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (w_in_free && i_in_valid) begin
            r_in <= i_in_word;
        end
    end

    // Point relative to the object, vertex unpack, saturated vertex count
    always_comb begin
        w_px     = PT_W'(r_in.query_x) - PT_W'(r_in.object_x);
        w_py     = PT_W'(r_in.query_y) - PT_W'(r_in.object_y);
        w_nvert  = (r_vcnt > CNT_W'(LANES)) ? CNT_W'(LANES) : r_vcnt;
        w_enough = w_nvert >= CNT_W'(3);
        for (int v = 0; v < LANES; v++) begin
            w_vx[v] = r_pair[v / 2][(v % 2) * 2 * VTX_W +: VTX_W];
            w_vy[v] = r_pair[v / 2][(v % 2) * 2 * VTX_W + VTX_W +: VTX_W];
        end
    end

    // One lane per edge; the last active edge closes back to vertex 0
    for (genvar g = 0; g < LANES; g++) begin : g_edge
        localparam int NEXT = (g + 1) % LANES;
        logic w_last;
        logic w_active;

        assign w_last   = (CNT_W'(g + 1) == w_nvert);
        assign w_active = w_enough && (CNT_W'(g) < w_nvert);

        pipt_edge u_edge (
            .i_active (w_active),
            .i_px     (w_px),
            .i_py     (w_py),
            .i_xi     (w_vx[g]),
            .i_yi     (w_vy[g]),
            .i_xj     (w_last ? w_vx[0] : w_vx[NEXT]),
            .i_yj     (w_last ? w_vy[0] : w_vy[NEXT]),
            .o_hit    (w_hit[g])
        );
    end

    // Count crossings
    always_comb begin
        w_sum = '0;
        for (int k = 0; k < LANES; k++) begin
            w_sum = w_sum + CNT_W'(w_hit[k]);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_out_free && r_in_vld) begin
            r_out.crossing_count <= w_sum;
            r_out.inside_res     <= w_sum[0];
        end
    end

    assign o_in_ready  = w_in_free;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    // Input stalls only with both stages full and the receiver stalling
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_vld && r_out_vld && !i_out_ready))
        else $error("input stalled with room in the pipeline");

    // Parity flag follows the crossing count
    a_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.inside_res == o_out_word.crossing_count[0]))
        else $error("inside flag disagrees with crossing count");

    // No more crossings than edges
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.crossing_count <= CNT_W'(LANES)))
        else $error("crossing count above edge count");

    // A stalled result word stays valid and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word changed during stall");
`endif

endmodule

FILE: bench/point_in_polygon_test_unit_tb.sv
`timescale 1ns / 100ps

module point_in_polygon_test_unit_tb;
    import pipt_pkg::*;

    localparam int          IDLE_PCT        = 23;
    localparam int          PHASES          = 12;
    localparam int          WORDS_PER_PHASE = 70;
    localparam int          QUIET_PHASE     = 5;
    localparam int          PAUSE_PHASE     = 3;
    localparam int          DRAIN_CYCLES    = 6;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int          COORD_MAX       = (1 << (COORD_WIDTH - 1)) - 1;
    localparam int          COORD_MIN       = -(1 << (COORD_WIDTH - 1));
    localparam int          VTX_MAX         = (1 << (VTX_W - 1)) - 1;
    localparam int          VTX_MIN         = -(1 << (VTX_W - 1));

    // indexes outside the register map, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    // Expected crossing results, predicted from a private copy of the registers
    class hit_scoreboard;
        logic [CNT_W-1:0]  vertex_count;
        logic [PAIR_W-1:0] vertex_pair [PAIR_REGS];
        t_out_word         expected_hits [$];
        int unsigned       mismatches;
        int unsigned       results_seen;

        function new();
            vertex_count = '0;
            foreach (vertex_pair[k]) vertex_pair[k] = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [PAIR_W-1:0] data);
            case (idx)
                REG_VERTEX_COUNT: vertex_count = data[CNT_W-1:0];
                REG_PAIR_0, REG_PAIR_1, REG_PAIR_2, REG_PAIR_3: begin
                    vertex_pair[idx - 1] = data;
                end
                default: ;
            endcase
        endfunction

        function void vertex_at(int k, output longint vx, output longint vy);
            logic [PAIR_W-1:0]       pair_bits;
            logic signed [VTX_W-1:0] cx;
            logic signed [VTX_W-1:0] cy;
            pair_bits = vertex_pair[k / 2];
            cx = pair_bits[(k % 2) * 2 * VTX_W +: VTX_W];
            cy = pair_bits[(k % 2) * 2 * VTX_W + VTX_W +: VTX_W];
            vx = cx;
            vy = cy;
        endfunction

        // Count edges crossed by the rightward ray from the query point
        function t_out_word predict_crossings(t_in_word q);
            int        n;
            int        j;
            int        crossed;
            longint    px, py, xi, yi, xj, yj, d, lhs, rhs;
            t_out_word r;
            n  = (vertex_count > LANES) ? LANES : int'(vertex_count);
            px = longint'($signed(q.query_x)) - longint'($signed(q.object_x));
            py = longint'($signed(q.query_y)) - longint'($signed(q.object_y));
            crossed = 0;
            if (n >= 3) begin
                for (int i = 0; i < n; i++) begin
                    j = (i + 1 == n) ? 0 : i + 1;
                    vertex_at(i, xi, yi);
                    vertex_at(j, xj, yj);
                    if ((yi > py) != (yj > py)) begin
                        d   = yj - yi;
                        lhs = (px - xi) * d;
                        rhs = (xj - xi) * (py - yi);
                        if ((d > 0) ? (lhs < rhs) : (lhs > rhs)) crossed++;
                    end
                end
            end
            r.inside_res     = crossed[0];
            r.crossing_count = crossed[CNT_W-1:0];
            return r;
        endfunction

        function void note_query(t_in_word q);
            expected_hits.push_back(predict_crossings(q));
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction

        task report(string msg);
            if (mismatches < 100) $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_result(t_out_word got);
            t_out_word want;
            results_seen++;
            if (expected_hits.size() == 0) begin
                report($sformatf("result word %0d arrived with nothing expected", results_seen));
                return;
            end
            want = expected_hits.pop_front();
            if (got.inside_res !== want.inside_res)
                report($sformatf("word %0d inside_res got %b want %b",
                                 results_seen, got.inside_res, want.inside_res));
            if (got.crossing_count !== want.crossing_count)
                report($sformatf("word %0d crossing_count got %0d want %0d",
                                 results_seen, got.crossing_count, want.crossing_count));
        endtask
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [PAIR_W-1:0]    cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_word             in_word   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_word            out_word;

    logic                 quiet     = 1'b0;
    int unsigned          cycle_count = 0;
    int unsigned          queries_sent = 0;
    int unsigned          settings_loaded = 0;
    hit_scoreboard        book;

    // polygon being programmed, as vertex offsets
    int                   vx_set [REG_VERTICES];
    int                   vy_set [REG_VERTICES];
    int                   poly_count;
    int                   poly_scale;

    point_in_polygon_test_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Count cycles and give up at the limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, book.pending());
        $display("FAILURE");
        $finish;
    end

    // Stall the result side at random, except in quiet stretches
    always @(posedge clk) begin
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // Check each accepted result word
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) book.check_result(out_word);
    end

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic t_in_word make_query(int qx, int qy, int ox, int oy);
        t_in_word q;
        q.query_x  = qx[COORD_WIDTH-1:0];
        q.query_y  = qy[COORD_WIDTH-1:0];
        q.object_x = ox[COORD_WIDTH-1:0];
        q.object_y = oy[COORD_WIDTH-1:0];
        return q;
    endfunction

    // Mostly points near the polygon, level with a vertex or in line with one, some pure noise
    function automatic t_in_word random_query();
        int ox, oy, k, span, sel;
        span = poly_scale + poly_scale / 4 + 4;
        ox   = rand_between(-440000, 440000);
        oy   = rand_between(-440000, 440000);
        k    = $urandom_range(0, REG_VERTICES - 1);
        sel  = $urandom_range(99);
        if (sel < 55)
            return make_query(ox + rand_between(-span, span), oy + rand_between(-span, span),
                              ox, oy);
        if (sel < 75)
            return make_query(ox + vx_set[k] + rand_between(-2, 2), oy + vy_set[k], ox, oy);
        if (sel < 85)
            return make_query(ox + vx_set[k], oy + rand_between(-span, span), ox, oy);
        return make_query($urandom, $urandom, $urandom, $urandom);
    endfunction

    function automatic logic [PAIR_W-1:0] packed_pair(int k);
        return {vy_set[2*k+1][VTX_W-1:0], vx_set[2*k+1][VTX_W-1:0],
                vy_set[2*k][VTX_W-1:0],   vx_set[2*k][VTX_W-1:0]};
    endfunction

    // Hold one input word until accepted, then idle at random
    task automatic push_query(input t_in_word q);
        in_valid <= 1'b1;
        in_word  <= q;
        do @(posedge clk); while (!in_ready);
        book.note_query(q);
        queries_sent++;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Drop valid and wait for every expected result, then let the pipe settle
    task automatic drain();
        in_valid <= 1'b0;
        while (book.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAIR_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        book.set_reg(idx, data);
    endtask

    // Program count and all vertex pairs; junk above the count field must be dropped
    task automatic load_polygon();
        logic [PAIR_W-1:0] count_bits;
        count_bits = {$urandom, $urandom};
        count_bits[CNT_W-1:0] = poly_count[CNT_W-1:0];
        write_reg(REG_VERTEX_COUNT, count_bits);
        for (int k = 0; k < PAIR_REGS; k++)
            write_reg(CFG_IDX_W'(REG_PAIR_0 + k), packed_pair(k));
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task automatic random_polygon();
        int pick;
        pick = $urandom_range(2);
        poly_scale = (pick == 0) ? 256 : (pick == 1) ? 2048 : VTX_MAX;
        for (int k = 0; k < REG_VERTICES; k++) begin
            vx_set[k] = rand_between(-poly_scale, poly_scale);
            vy_set[k] = rand_between(-poly_scale, poly_scale);
            if ($urandom_range(15) == 0) vx_set[k] = $urandom_range(1) ? VTX_MIN : VTX_MAX;
            if ($urandom_range(15) == 0) vy_set[k] = $urandom_range(1) ? VTX_MIN : VTX_MAX;
        end
        poly_count = ($urandom_range(99) < 80) ? $urandom_range(3, REG_VERTICES)
                                               : $urandom_range(0, 15);
    endtask

    task automatic set_vertices(input int xs [REG_VERTICES], input int ys [REG_VERTICES],
                                input int count, input int scale);
        vx_set     = xs;
        vy_set     = ys;
        poly_count = count;
        poly_scale = scale;
    endtask

    initial begin
        book = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unit square around the object: inside, outside, rays through corners and edges
        set_vertices('{-256, 256, 256, -256, 0, 0, 0, 0},
                     '{-256, -256, 256, 256, 0, 0, 0, 0}, 4, 256);
        load_polygon();
        push_query(make_query(0, 0, 0, 0));
        push_query(make_query(1000, 1000, 1000, 1000));
        push_query(make_query(512, 0, 0, 0));
        push_query(make_query(-512, 0, 0, 0));
        push_query(make_query(0, -256, 0, 0));
        push_query(make_query(0, 256, 0, 0));
        push_query(make_query(256, 0, 0, 0));
        push_query(make_query(-256, 100, 0, 0));
        push_query(make_query(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN));
        push_query(make_query(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
        push_query(make_query(COORD_MAX, 0, COORD_MAX, 0));
        push_query(make_query(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));

        // Triangle at the vertex extremes
        drain();
        set_vertices('{VTX_MIN, VTX_MAX, 0, 0, 0, 0, 0, 0},
                     '{VTX_MIN, VTX_MIN, VTX_MAX, 0, 0, 0, 0, 0}, 3, VTX_MAX);
        load_polygon();
        push_query(make_query(0, 0, 0, 0));
        push_query(make_query(VTX_MAX, VTX_MIN, 0, 0));
        push_query(make_query(VTX_MIN, 0, 0, 0));
        push_query(make_query(0, VTX_MAX, 0, 0));

        // Concave eight-point star, then a count past the register limit
        drain();
        set_vertices('{-512, 0, 512, 128, 512, 0, -512, -128},
                     '{-512, -128, -512, 0, 512, 128, 512, 0}, REG_VERTICES, 512);
        load_polygon();
        push_query(make_query(0, 0, 0, 0));
        push_query(make_query(-300, 0, 0, 0));
        push_query(make_query(400, -400, 0, 0));
        drain();
        poly_count = 15;
        load_polygon();
        push_query(make_query(0, 0, 0, 0));
        push_query(make_query(-300, 0, 0, 0));

        // Too few vertices: never inside
        for (int c = 2; c >= 0; c--) begin
            drain();
            poly_count = c;
            load_polygon();
            push_query(make_query(0, 0, 0, 0));
        end

        // Writes to unmapped indexes must leave the star intact
        drain();
        poly_count = REG_VERTICES;
        load_polygon();
        write_reg(REG_UNMAPPED_LO, {$urandom, $urandom});
        write_reg(REG_UNMAPPED_HI, {$urandom, $urandom});
        cfg_we <= 1'b0;
        push_query(make_query(-300, 0, 0, 0));

        // Random polygons with streams of nearby query points
        for (int p = 0; p < PHASES; p++) begin
            drain();
            quiet = (p == QUIET_PHASE);
            random_polygon();
            load_polygon();
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (p == PAUSE_PHASE && n == WORDS_PER_PHASE / 2) drain();
                push_query(random_query());
            end
        end
        drain();
        quiet = 1'b0;

        $display("ran %0d point queries against %0d polygon settings, %0d results checked",
                 queries_sent, settings_loaded, book.results_seen);
        $display("covered square, extreme triangle, concave star, saturated and short counts");
        if (book.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", book.mismatches);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/pipt_pkg.sv
rtl/pipt_edge.sv
rtl/point_in_polygon_test_unit.sv
bench/point_in_polygon_test_unit_tb.sv
